// ----- design/assert_macros.svh -----
// Assertion macros for the design files; only the solver unit includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset
`define PDS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pds_pkg.sv -----
package pds_pkg;

  // Loop bounds of the divider search
  localparam int DIVIDER_MAX_DEF     = 32;
  localparam int VCO_DIVIDER_MAX_DEF = 6;

  // Shared multiplier and divider widths
  localparam int OPA_W  = 60;
  localparam int OPB_W  = 19;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int DVD_W  = 64;
  localparam int DVS_W  = 32;

  // PLL limits and fixed plans
  localparam logic [63:0] B_MAX      = 64'd8191;
  localparam logic [63:0] B_LIMIT    = 64'd8192;
  localparam logic [5:0]  A_MAX      = 6'd63;
  localparam logic [12:0] BYP_B      = 13'd4375;
  localparam logic [5:0]  BYP_P      = 6'd16;
  localparam logic [2:0]  BYP_PLOG   = 3'd4;
  localparam logic [13:0] BYP_R      = 14'd1000;
  localparam logic [13:0] EXT_R      = 14'd100;
  localparam logic [31:0] EXT_MIN_HZ = 32'd1000000;
  localparam logic [63:0] INT_N      = 64'd70000;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_LOW    = 2'd1;
  localparam logic [1:0] ST_NOPLAN = 2'd2;
  localparam logic [1:0] ST_INFEAS = 2'd3;

  // Register indexes
  localparam logic [2:0] CFG_USE_EXT = 3'd0;
  localparam logic [2:0] CFG_EXT_HZ  = 3'd1;
  localparam logic [2:0] CFG_OSC_HZ  = 3'd2;
  localparam logic [2:0] CFG_MAX_ERR = 3'd3;
  localparam logic [2:0] CFG_MIN_OUT = 3'd4;
  localparam logic [2:0] CFG_VCO_MIN = 3'd5;
  localparam logic [2:0] CFG_VCO_MAX = 3'd6;

  // Register reset values
  localparam logic [31:0] RST_EXT_HZ  = 32'd10000000;
  localparam logic [31:0] RST_OSC_HZ  = 32'd40000000;
  localparam logic [31:0] RST_MAX_ERR = 32'd0;
  localparam logic [31:0] RST_MIN_OUT = 32'd1;
  localparam logic [31:0] RST_VCO_MIN = 32'd2550000000;
  localparam logic [31:0] RST_VCO_MAX = 32'd2950000000;

endpackage

// ----- design/pds_mul.sv -----
// Shared multiplier, product registered
module pds_mul import pds_pkg::*; (
  input  logic              clk,
  input  logic [OPA_W-1:0]  op_a,
  input  logic [OPB_W-1:0]  op_b,
  output logic [PROD_W-1:0] prod
);

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  assign prod = prod_r;

endmodule

// ----- design/pds_div.sv -----
// Restoring divider, one quotient bit a cycle
module pds_div import pds_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  // trial subtract
  assign rem_sh = {rem_r, quo_r[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // pulse after the last quotient bit
      done_r <= busy_r && !start && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[DVD_W-2:0], fits};
        rem_r <= fits ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- design/pll_divider_solver_unit.sv -----
// Channel | Dir | Payload
// in_     | in  | tdata[31:0] requested_hz
// out_    | out | tdata: settings word; tuser: bypass
// cfg_    | in  | cfg_index selects register, cfg_data value
//
// One word at a time; in_tready and cfg_ready are high only while idle.
// An external plan costs one division; each divider combination uses
// the shared multiplier, with up to 2640 combinations and an early exit
// on a match; no match adds a further division.
// rst_n is synchronous; the result register holds while out_tvalid is high and out_tready is low.
`include "assert_macros.svh"
module pll_divider_solver_unit import pds_pkg::*; #(
  parameter int DIVIDER_MAX     = DIVIDER_MAX_DEF,
  parameter int VCO_DIVIDER_MAX = VCO_DIVIDER_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // requested_hz
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], exact_match[2], counter_a[8:3], counter_b[21:9], prescaler[27:22],
  // ref_divider[41:28], vco_divider[44:42], out_divider_one[50:45],
  // out_divider_two[56:51], zero fill above
  output logic [63:0] out_tdata,
  output logic        out_tuser,  // bypass
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_EXT1, S_EXT2, S_EWAIT, S_ECHK1, S_ECHK2, S_ECHK3, S_PRE,
    S_FR, S_MR, S_FN, S_INIT, S_T, S_TOL, S_CMP, S_LHS, S_RHS, S_NEXT,
    S_RECOMP, S_RDIV, S_RWAIT, S_SPLIT, S_CHK, S_V1, S_V2, S_V3, S_DONE
  } state_t;

  typedef enum logic [1:0] { K_NORM, K_BYP, K_ZERO } kind_t;

  // configuration registers
  logic        use_ext_r;
  logic [31:0] ext_hz_r, osc_hz_r, max_err_r, min_out_r, vco_min_r, vco_max_r;

  state_t            state_r;
  kind_t             kind_r;
  logic [1:0]        status_r;
  logic              exact_r, have_r;
  logic [31:0]       freq_r, clk_hz_r;
  logic [63:0]       n_r, b_r;
  logic [5:0]        a_r, p_r;
  logic [2:0]        plog_r, pidx_r;
  logic [13:0]       r_r;
  logic [OPA_W-1:0]  fr_r, mr_r, fnum_r, e_r, tol_r, best_e_r, v_r;
  logic [PROD_W-1:0] lhs_r;
  logic [12:0]       d_r, best_d_r;
  logic [2:0]        i_r, bi_r;
  logic [5:0]        j_r, k_r, bj_r, bk_r;

  logic              out_tvalid_r, out_tuser_r;
  logic [63:0]       out_tdata_r;

  // shared units
  logic [OPA_W-1:0]  op_a;
  logic [OPB_W-1:0]  op_b;
  logic [PROD_W-1:0] mul_p;
  logic              div_start, div_done;
  logic [DVD_W-1:0]  div_q;
  logic [DVS_W-1:0]  div_rem;

  pds_mul u_mul (.clk(clk), .op_a(op_a), .op_b(op_b), .prod(mul_p));

  assign div_start = (state_r == S_EXT2) || (state_r == S_RDIV);

  pds_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(mul_p[DVD_W-1:0]),
    .divisor(clk_hz_r), .done(div_done), .quotient(div_q), .remainder(div_rem)
  );

  // multiplier operand selection
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      S_EXT1:   begin op_a = OPA_W'(vco_min_r); op_b = OPB_W'(EXT_R); end
      S_ECHK1:  begin op_a = OPA_W'(vco_max_r); op_b = OPB_W'(EXT_R); end
      S_ECHK2:  begin op_a = OPA_W'(clk_hz_r);  op_b = n_r[OPB_W-1:0]; end
      S_FR:     begin op_a = OPA_W'(freq_r);    op_b = OPB_W'(r_r); end
      S_MR:     begin op_a = OPA_W'(max_err_r); op_b = OPB_W'(r_r); end
      S_FN:     begin op_a = OPA_W'(clk_hz_r);  op_b = n_r[OPB_W-1:0]; end
      S_T:      begin op_a = fr_r;              op_b = OPB_W'(d_r); end
      S_TOL:    begin op_a = mr_r;              op_b = OPB_W'(d_r); end
      S_CMP:    begin op_a = e_r;               op_b = OPB_W'(best_d_r); end
      S_LHS:    begin op_a = best_e_r;          op_b = OPB_W'(d_r); end
      S_RECOMP: begin op_a = fr_r;              op_b = OPB_W'(best_d_r); end
      S_CHK:    begin op_a = OPA_W'(clk_hz_r);  op_b = n_r[OPB_W-1:0]; end
      S_V1:     begin op_a = OPA_W'(vco_min_r); op_b = OPB_W'(r_r); end
      S_V2:     begin op_a = OPA_W'(vco_max_r); op_b = OPB_W'(r_r); end
      default:  begin op_a = '0; op_b = '0; end
    endcase
  end

  // next divider combination
  logic [2:0]  i_nxt;
  logic [5:0]  j_nxt, k_nxt;
  logic        search_end;
  logic [12:0] d_nxt;

  always_comb begin
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    search_end = 1'b0;
    if (k_r < 6'(DIVIDER_MAX)) begin
      k_nxt = k_r + 6'd1;
    end else if (j_r < 6'(DIVIDER_MAX)) begin
      j_nxt = j_r + 6'd1;
      k_nxt = j_r + 6'd1;
    end else if (i_r < 3'(VCO_DIVIDER_MAX)) begin
      i_nxt = i_r + 3'd1;
      j_nxt = 6'd1;
      k_nxt = 6'd1;
    end else begin
      search_end = 1'b1;
    end
    d_nxt = 13'(13'(i_nxt) * 13'(j_nxt) * 13'(k_nxt));
  end

  // prescaler trial: 32 down to 2
  logic [2:0]  pre_log;
  logic [63:0] pre_b;
  logic [5:0]  pre_a;
  logic        pre_ok;

  always_comb begin
    pre_log = 3'd5 - pidx_r;
    pre_b   = n_r >> pre_log;
    pre_a   = 6'(n_r & ((64'd1 << pre_log) - 64'd1));
    pre_ok  = (pre_b != 64'd0) && (pre_b < B_LIMIT) &&
              ((pre_a == 6'd0) || ((pre_b > 64'(pre_a)) && (pre_b > 64'd3)));
  end

  logic [OPA_W-1:0] abs_err;
  assign abs_err = (fnum_r > mul_p[OPA_W-1:0]) ? fnum_r - mul_p[OPA_W-1:0]
                                               : mul_p[OPA_W-1:0] - fnum_r;

  logic out_free;
  assign out_free = !out_tvalid_r || out_tready;

  // settings word for the result register
  logic [63:0] done_data;
  logic        done_user;

  always_comb begin
    done_data = '0;
    done_user = 1'b0;
    case (kind_r)
      K_BYP: begin
        done_user        = 1'b1;
        done_data[1:0]   = ST_OK;
        done_data[21:9]  = BYP_B;
        done_data[27:22] = BYP_P;
        done_data[41:28] = BYP_R;
        done_data[44:42] = 3'd1;
        done_data[50:45] = 6'd1;
        done_data[56:51] = 6'd1;
      end
      K_ZERO: done_data[1:0] = status_r;
      default: begin
        done_data[1:0]   = status_r;
        done_data[2]     = exact_r;
        done_data[8:3]   = a_r;
        done_data[21:9]  = (b_r > B_MAX) ? 13'(B_MAX) : b_r[12:0];
        done_data[27:22] = p_r;
        done_data[41:28] = r_r;
        done_data[44:42] = bi_r;
        done_data[50:45] = bj_r;
        done_data[56:51] = bk_r;
      end
    endcase
  end

  // configuration port, open only between words
  assign cfg_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_ext_r <= 1'b0;
      ext_hz_r  <= RST_EXT_HZ;
      osc_hz_r  <= RST_OSC_HZ;
      max_err_r <= RST_MAX_ERR;
      min_out_r <= RST_MIN_OUT;
      vco_min_r <= RST_VCO_MIN;
      vco_max_r <= RST_VCO_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_USE_EXT: use_ext_r <= cfg_data[0];
        CFG_EXT_HZ:  ext_hz_r  <= cfg_data;
        CFG_OSC_HZ:  osc_hz_r  <= cfg_data;
        CFG_MAX_ERR: max_err_r <= cfg_data;
        CFG_MIN_OUT: min_out_r <= cfg_data;
        CFG_VCO_MIN: vco_min_r <= cfg_data;
        CFG_VCO_MAX: vco_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != S_DONE)) out_tvalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            freq_r  <= in_tdata;
            exact_r <= 1'b0;
            if (in_tdata == 32'd0) begin
              kind_r   <= K_BYP;
              status_r <= ST_OK;
              state_r  <= S_DONE;
            end else if (in_tdata < min_out_r) begin
              kind_r   <= K_ZERO;
              status_r <= ST_LOW;
              state_r  <= S_DONE;
            end else if (!use_ext_r) begin
              kind_r   <= K_NORM;
              status_r <= ST_OK;
              clk_hz_r <= osc_hz_r;
              p_r      <= BYP_P;
              plog_r   <= BYP_PLOG;
              b_r      <= 64'(BYP_B);
              a_r      <= 6'd0;
              r_r      <= BYP_R;
              n_r      <= INT_N;
              state_r  <= S_FR;
            end else begin
              clk_hz_r <= ext_hz_r;
              r_r      <= EXT_R;
              if (ext_hz_r < EXT_MIN_HZ) begin
                kind_r   <= K_ZERO;
                status_r <= ST_NOPLAN;
                state_r  <= S_DONE;
              end else begin
                kind_r   <= K_NORM;
                status_r <= ST_OK;
                state_r  <= S_EXT1;
              end
            end
          end
        end
        // external plan: N = ceil(100 * vco_min / fref)
        S_EXT1: state_r <= S_EXT2;
        S_EXT2: state_r <= S_EWAIT;
        S_EWAIT: begin
          if (div_done) begin
            n_r     <= div_q + 64'(div_rem != '0);
            state_r <= S_ECHK1;
          end
        end
        S_ECHK1: state_r <= S_ECHK2;
        S_ECHK2: begin
          tol_r   <= mul_p[OPA_W-1:0];
          state_r <= S_ECHK3;
        end
        S_ECHK3: begin
          pidx_r <= 3'd0;
          if (mul_p > PROD_W'(tol_r)) begin
            kind_r   <= K_ZERO;
            status_r <= ST_NOPLAN;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_PRE;
          end
        end
        S_PRE: begin
          if (pre_ok) begin
            p_r     <= 6'(7'd1 << pre_log);
            plog_r  <= pre_log;
            b_r     <= pre_b;
            a_r     <= pre_a;
            state_r <= S_FR;
          end else if (pidx_r == 3'd4) begin
            kind_r   <= K_ZERO;
            status_r <= ST_NOPLAN;
            state_r  <= S_DONE;
          end else begin
            pidx_r <= pidx_r + 3'd1;
          end
        end
        // products fixed for the whole search
        S_FR: state_r <= S_MR;
        S_MR: begin
          fr_r    <= mul_p[OPA_W-1:0];
          state_r <= S_FN;
        end
        S_FN: begin
          mr_r    <= mul_p[OPA_W-1:0];
          state_r <= S_INIT;
        end
        S_INIT: begin
          fnum_r  <= mul_p[OPA_W-1:0];
          i_r     <= 3'd2;
          j_r     <= 6'd1;
          k_r     <= 6'd1;
          d_r     <= 13'd2;
          have_r  <= 1'b0;
          state_r <= S_T;
        end
        // one divider combination
        S_T: state_r <= S_TOL;
        S_TOL: begin
          e_r     <= abs_err;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (PROD_W'(e_r) <= mul_p) begin
            exact_r <= 1'b1;
            bi_r    <= i_r;
            bj_r    <= j_r;
            bk_r    <= k_r;
            state_r <= S_CHK;
          end else if (!have_r) begin
            have_r   <= 1'b1;
            best_e_r <= e_r;
            best_d_r <= d_r;
            bi_r     <= i_r;
            bj_r     <= j_r;
            bk_r     <= k_r;
            state_r  <= S_NEXT;
          end else begin
            state_r <= S_LHS;
          end
        end
        S_LHS: begin
          lhs_r   <= mul_p;
          state_r <= S_RHS;
        end
        S_RHS: begin
          // strictly closer: ties keep the earlier set
          if (lhs_r < mul_p) begin
            best_e_r <= e_r;
            best_d_r <= d_r;
            bi_r     <= i_r;
            bj_r     <= j_r;
            bk_r     <= k_r;
          end
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          i_r     <= i_nxt;
          j_r     <= j_nxt;
          k_r     <= k_nxt;
          d_r     <= d_nxt;
          state_r <= search_end ? S_RECOMP : S_T;
        end
        // no match: N = floor(d * freq * R / fref)
        S_RECOMP: begin
          if (clk_hz_r == 32'd0) begin
            n_r     <= 64'd0;
            state_r <= S_SPLIT;
          end else begin
            state_r <= S_RDIV;
          end
        end
        S_RDIV: state_r <= S_RWAIT;
        S_RWAIT: begin
          if (div_done) begin
            n_r     <= div_q;
            state_r <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          b_r     <= n_r >> plog_r;
          a_r     <= 6'(n_r & ((64'd1 << plog_r) - 64'd1));
          state_r <= S_CHK;
        end
        // feasibility
        S_CHK: begin
          if ((64'(a_r) > b_r) || (a_r > A_MAX) || (b_r == 64'd0) || (b_r > B_MAX)) begin
            status_r <= ST_INFEAS;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_V1;
          end
        end
        S_V1: begin
          v_r     <= mul_p[OPA_W-1:0];
          state_r <= S_V2;
        end
        S_V2: begin
          if (PROD_W'(v_r) < mul_p) status_r <= ST_INFEAS;
          state_r <= S_V3;
        end
        S_V3: begin
          if (PROD_W'(v_r) > mul_p) status_r <= ST_INFEAS;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tuser_r  <= done_user;
            out_tdata_r  <= done_data;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // accepted word keeps the block busy
  `PDS_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")
  // a good non-bypass result has a usable B and A
  `PDS_ASSERT_SAME(a_ok_counters, out_tvalid && !out_tuser && out_tdata[1:0] == ST_OK,
    out_tdata[21:9] != 13'd0 && {7'd0, out_tdata[8:3]} <= out_tdata[21:9], "bad counters")
  // bypass words carry the fixed plan
  `PDS_ASSERT_SAME(a_bypass_plan, out_tvalid && out_tuser,
    out_tdata[1:0] == ST_OK && out_tdata[27:22] == BYP_P, "bad bypass word")

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
  import pds_pkg::*;

  localparam longint CYCLE_LIMIT = 40000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  typedef struct packed {
    logic [63:0] data;
    logic        user;
  } settings_t;

  // Requests waiting to be sent, settings words still owed by the block
  logic [31:0] pending_req[$];
  settings_t   owed_settings[$];

  // Local copy of the register file
  logic        sel_ext;
  logic [31:0] ext_hz, osc_hz, max_err, min_out, vco_lo, vco_hi;

  int     errors;
  longint cycles;
  int     send_gap;
  int     recv_stall;
  bit     no_idle;
  bit     hold_send;

  pll_divider_solver_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // e1/d1 < e2/d2 without division
  function automatic bit ratio_below(logic [63:0] e1, logic [63:0] d1,
                                     logic [63:0] e2, logic [63:0] d2);
    logic [127:0] lhs, rhs;
    lhs = {64'd0, e1} * {64'd0, d2};
    rhs = {64'd0, e2} * {64'd0, d1};
    return lhs < rhs;
  endfunction

  // Expected synthesizer settings for one request
  function automatic settings_t solve_plan(logic [31:0] req);
    logic [63:0] f, ref_hz, n, p, b, a, r, best_e, best_d, fnum, d, t, e, vco, bq;
    logic [63:0] pre[5];
    logic [1:0]  st;
    int          dv, d1, d2;
    bit          have, exact, found;
    settings_t   res;
    pre = '{64'd32, 64'd16, 64'd8, 64'd4, 64'd2};
    f = {32'd0, req};
    res = '0;
    have = 0; exact = 0; found = 0;
    best_e = 0; best_d = 1;
    dv = 1; d1 = 1; d2 = 1;
    st = ST_OK;
    if (f == 0) begin
      res.data = {7'd0, 6'd1, 6'd1, 3'd1, BYP_R, BYP_P, BYP_B, 6'd0, 1'b0, ST_OK};
      res.user = 1'b1;
      return res;
    end
    if (req < min_out) begin
      res.data = {62'd0, ST_LOW};
      return res;
    end
    if (!sel_ext) begin
      ref_hz = {32'd0, osc_hz};
      p = BYP_P; b = BYP_B; a = 0; r = BYP_R;
    end else begin
      ref_hz = {32'd0, ext_hz};
      r = EXT_R; p = 0; b = 0; a = 0;
      if (ext_hz >= EXT_MIN_HZ) begin
        n = ({32'd0, vco_lo} * r + ref_hz - 1) / ref_hz;
        if (n * ref_hz <= {32'd0, vco_hi} * r) begin
          for (int i = 0; i < 5 && !found; i++) begin
            bq = n / pre[i];
            if (bq == 0 || bq >= B_LIMIT) continue;
            if ((n % pre[i]) == 0 || (bq > (n % pre[i]) && bq > 3)) begin
              p = pre[i]; b = bq; a = n % pre[i];
              found = 1;
            end
          end
        end
      end
      if (!found) begin
        res.data = {62'd0, ST_NOPLAN};
        return res;
      end
    end

    // Divider search against the chosen VCO
    fnum = ref_hz * (p * b + a);
    for (int i = 2; i <= VCO_DIVIDER_MAX_DEF && !exact; i++)
      for (int j = 1; j <= DIVIDER_MAX_DEF && !exact; j++)
        for (int k = j; k <= DIVIDER_MAX_DEF && !exact; k++) begin
          d = i * j * k;
          t = f * r * d;
          e = fnum > t ? fnum - t : t - fnum;
          if (e <= {32'd0, max_err} * r * d) begin
            exact = 1; dv = i; d1 = j; d2 = k;
          end else if (!have || ratio_below(e, d, best_e, best_d)) begin
            have = 1; best_e = e; best_d = d;
            dv = i; d1 = j; d2 = k;
          end
        end

    // Closest set: recompute the counters
    if (!exact) begin
      d = dv * d1 * d2;
      n = (ref_hz == 0) ? 64'd0 : (d * f * r) / ref_hz;
      b = n / p;
      a = n % p;
    end

    if (a > b || a > A_MAX || b == 0 || b > B_MAX) st = ST_INFEAS;
    else begin
      vco = ref_hz * (p * b + a);
      if (vco < {32'd0, vco_lo} * r || vco > {32'd0, vco_hi} * r) st = ST_INFEAS;
    end
    res.data = {7'd0, d2[5:0], d1[5:0], dv[2:0], r[13:0], p[5:0],
                (b > B_MAX) ? 13'd8191 : b[12:0], a[5:0], exact, st};
    res.user = 1'b0;
    return res;
  endfunction

  // Driver: one request word per handshake, random gap between words unless no_idle is set
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        owed_settings.push_back(solve_plan(in_tdata));
        in_tvalid <= 1'b0;
        send_gap  <= no_idle ? 0 : $urandom_range(0, 7);
      end else if (!in_tvalid) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        else if (pending_req.size() > 0 && !hold_send) begin
          in_tdata  <= pending_req.pop_front();
          in_tvalid <= 1'b1;
        end
      end
    end
  end

  // Monitor: compare each settings word field by field
  always @(posedge clk) begin
    settings_t   want;
    string       names[10];
    int          lsb[10], wid[10];
    logic [63:0] got_v, want_v, got_w, want_w;
    int          draw;
    names = '{"status", "exact_match", "counter_a", "counter_b", "prescaler",
              "ref_divider", "vco_divider", "out_divider_one", "out_divider_two",
              "bypass"};
    lsb = '{0, 2, 3, 9, 22, 28, 42, 45, 51, 57};
    wid = '{2, 1, 6, 13, 6, 14, 3, 6, 6, 1};
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (owed_settings.size() == 0) begin
          $error("settings word with none expected: %h", out_tdata);
          errors++;
        end else begin
          want = owed_settings.pop_front();
          // tuser rides as bit 57 so one loop covers every field
          got_w  = out_tdata;  got_w[57] = out_tuser;
          want_w = want.data;  want_w[57] = want.user;
          for (int i = 0; i < 10; i++) begin
            got_v  = (got_w >> lsb[i]) & ((64'd1 << wid[i]) - 1);
            want_v = (want_w >> lsb[i]) & ((64'd1 << wid[i]) - 1);
            if (got_v !== want_v) begin
              $error("%s: expected %0d, got %0d", names[i], want_v, got_v);
              errors++;
            end
          end
        end
        draw = no_idle ? 0 : $urandom_range(0, 7);
        recv_stall <= draw;
        out_tready <= (draw == 0);
      end else if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_tready <= (recv_stall == 1);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL pll_divider_solver_unit");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_USE_EXT: sel_ext = val[0];
      CFG_EXT_HZ:  ext_hz  = val;
      CFG_OSC_HZ:  osc_hz  = val;
      CFG_MAX_ERR: max_err = val;
      CFG_MIN_OUT: min_out = val;
      CFG_VCO_MIN: vco_lo  = val;
      CFG_VCO_MAX: vco_hi  = val;
      default: ;
    endcase
  endtask

  task automatic reg_done();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every request is sent and answered, then let the block settle;
  // polled on the falling edge so handshake updates have landed
  task automatic drain();
    while (pending_req.size() > 0 || in_tvalid || owed_settings.size() > 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_req();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 32'd0;
    if (pick < 3) return $urandom();
    return $urandom_range(1000000, 1500000000);
  endfunction

  initial begin
    errors = 0; cycles = 0;
    send_gap = 0; recv_stall = 0;
    no_idle = 0; hold_send = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    sel_ext = 1'b0;
    ext_hz = RST_EXT_HZ; osc_hz = RST_OSC_HZ; max_err = RST_MAX_ERR;
    min_out = RST_MIN_OUT; vco_lo = RST_VCO_MIN; vco_hi = RST_VCO_MAX;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: bypass, the smallest and largest requests, typical rates
    pending_req = '{32'd0, 32'd1, 32'hFFFFFFFF, 32'd100000000, 32'd491666666,
                    32'd245760000};
    drain();

    // External reference with tolerance and a minimum
    reg_write(CFG_USE_EXT, 32'd1);
    reg_write(CFG_EXT_HZ, 32'd10000000);
    reg_write(CFG_MAX_ERR, 32'd1000);
    reg_write(CFG_MIN_OUT, 32'd1000);
    reg_done();
    pending_req = '{32'd0, 32'd999, 32'd1000, 32'd10000000, 32'd80000000};
    drain();

    // External reference too slow for any plan
    reg_write(CFG_EXT_HZ, 32'd999999);
    reg_done();
    pending_req = '{32'd5000000, 32'd0};
    drain();

    // Widest VCO window and fastest reference
    reg_write(CFG_EXT_HZ, 32'hFFFFFFFF);
    reg_write(CFG_VCO_MIN, 32'd0);
    reg_write(CFG_VCO_MAX, 32'hFFFFFFFF);
    reg_write(CFG_MAX_ERR, 32'd0);
    reg_done();
    pending_req = '{32'd1000, 32'd300000000, 32'hFFFFFFFF};
    drain();

    // On-board oscillator stopped
    reg_write(CFG_USE_EXT, 32'd0);
    reg_write(CFG_OSC_HZ, 32'd0);
    reg_done();
    pending_req = '{32'd100000000, 32'd7};
    drain();

    // Oscillator, tolerance and minimum output at their top values
    reg_write(CFG_OSC_HZ, 32'hFFFFFFFF);
    reg_write(CFG_MAX_ERR, 32'hFFFFFFFF);
    reg_write(CFG_MIN_OUT, 32'hFFFFFFFF);
    reg_done();
    pending_req = '{32'hFFFFFFFE, 32'hFFFFFFFF};
    drain();

    // Random settings, mostly near the usual operating range
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(CFG_USE_EXT, $urandom_range(0, 1));
      reg_write(CFG_EXT_HZ, ($urandom_range(0, 3) == 0) ? $urandom()
                            : $urandom_range(1000000, 200000000));
      reg_write(CFG_OSC_HZ, ($urandom_range(0, 3) == 0) ? $urandom()
                            : $urandom_range(1000000, 100000000));
      reg_write(CFG_MAX_ERR, ($urandom_range(0, 3) == 0) ? $urandom()
                             : $urandom_range(0, 2000000));
      reg_write(CFG_MIN_OUT, ($urandom_range(0, 3) == 0) ? $urandom()
                             : $urandom_range(0, 2000000));
      if ($urandom_range(0, 2) == 0) begin
        reg_write(CFG_VCO_MIN, $urandom());
        reg_write(CFG_VCO_MAX, $urandom());
      end else begin
        reg_write(CFG_VCO_MIN, RST_VCO_MIN);
        reg_write(CFG_VCO_MAX, RST_VCO_MAX);
      end
      reg_done();
      no_idle = (ph == 2);
      for (int i = 0; i < 33; i++) begin
        pending_req.push_back(rand_req());
        // One pause of the sender until the block has answered everything
        if (ph == 3 && i == 15) begin
          while (pending_req.size() > 0 || in_tvalid) @(negedge clk);
          hold_send = 1;
          while (owed_settings.size() > 0) @(negedge clk);
          hold_send = 0;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS pll_divider_solver_unit");
    end else begin
      $display("FAIL pll_divider_solver_unit");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+design
design/pds_pkg.sv
design/pds_mul.sv
design/pds_div.sv
design/pll_divider_solver_unit.sv
dv/tb_top.sv
